[hw/rtl/alt_pkg.sv]
// Shared types, constants and character helpers for the assembler line tokenizer.
// No dependencies.
`default_nettype none

package alt_pkg;

    typedef enum logic [1:0] {
        KIND_LABEL   = 2'd0,
        KIND_OPCODE  = 2'd1,
        KIND_OPERAND = 2'd2,
        KIND_END     = 2'd3
    } alt_kind_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMMENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_SEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABEL    = 3'd4;

    localparam logic [7:0] RST_LINE_COMMENT = 8'd42;
    localparam logic [7:0] RST_COMMENT      = 8'd59;
    localparam logic [7:0] RST_LABEL_SEP    = 8'd58;
    localparam logic [7:0] RST_QUOTE        = 8'd39;
    localparam logic [5:0] RST_MAX_LABEL    = 6'd8;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One front-end decision: an optional field char and an optional end marker.
    typedef struct packed {
        logic       has_char;
        alt_kind_t  kind;
        logic [7:0] ch;
        logic       line_end;
    } alt_rec_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
               (c == CH_VTAB) || (c == CH_FFEED) || (c == CH_RETURN);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? (c - CASE_DELTA) : c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/alt_if.sv]
// Handshake channel interfaces for the tokenizer input and result items.
// No dependencies.
`default_nettype none

interface alt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       line_last;

    modport source (output valid, output in_char, output line_last, input ready);
    modport sink   (input valid, input in_char, input line_last, output ready);
endinterface

interface alt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] field_kind;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output field_kind, output out_char, output last_of_run,
                    input ready);
    modport sink   (input valid, input field_kind, input out_char, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/alt_front.sv]
// Front end: config registers and the per-line field state machine.
// Items with a field char or line end become records. Depends on alt_pkg, alt_if.
`default_nettype none

module alt_front
    import alt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    alt_in_if.sink                    in_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 q_full,
    output logic                      q_push,
    output alt_rec_t                  q_data
);

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_LABEL   = 3'd1,
        PH_LSKIP   = 3'd2,
        PH_OPBLANK = 3'd3,
        PH_OPCODE  = 3'd4,
        PH_OPERAND = 3'd5,
        PH_STRING  = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [5:0] label_count_reg, label_count_next;
    logic       prev_f_reg, prev_f_next;

    logic [7:0] line_comment_reg;
    logic [7:0] comment_reg;
    logic [7:0] label_sep_reg;
    logic [7:0] quote_reg;
    logic [5:0] max_label_reg;

    logic       accept;
    logic [7:0] c;
    logic [7:0] cu;
    logic       blank;
    logic       go;
    logic       emit;
    alt_kind_t  kind;
    logic [7:0] ch;

    assign c      = in_ch.in_char;
    assign cu     = to_upper(c);
    assign blank  = is_blank(c);
    assign accept = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !q_full;

    // Phases only move forward within one item, so a single ordered pass suffices.
    always_comb
    begin
        phase_next       = phase_reg;
        label_count_next = label_count_reg;
        prev_f_next      = prev_f_reg;
        go               = 1'b1;
        emit             = 1'b0;
        kind             = KIND_LABEL;
        ch               = cu;

        if (go && phase_next == PH_START)
        begin
            go = 1'b0;
            if (c == line_comment_reg)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_LABEL;
                go         = 1'b1;
            end
        end

        if (go && phase_next == PH_LABEL)
        begin
            go = 1'b0;
            if (blank || c == comment_reg || c == label_sep_reg ||
                label_count_reg >= max_label_reg)
            begin
                phase_next = PH_LSKIP;
                go         = 1'b1;
            end
            else
            begin
                emit             = 1'b1;
                kind             = KIND_LABEL;
                ch               = cu;
                label_count_next = label_count_reg + 6'd1;
            end
        end

        if (go && phase_next == PH_LSKIP)
        begin
            go = 1'b0;
            if (c == label_sep_reg)
            begin
                phase_next = PH_OPBLANK;
            end
            else if (blank || c == comment_reg)
            begin
                phase_next = PH_OPBLANK;
                go         = 1'b1;
            end
        end

        if (go && phase_next == PH_OPBLANK)
        begin
            go = 1'b0;
            if (c != CH_SPACE && c != CH_TAB)
            begin
                phase_next = PH_OPCODE;
                go         = 1'b1;
            end
        end

        if (go && phase_next == PH_OPCODE)
        begin
            go = 1'b0;
            if (blank || c == comment_reg)
            begin
                phase_next = PH_OPERAND;
                go         = 1'b1;
            end
            else
            begin
                emit = 1'b1;
                kind = KIND_OPCODE;
                ch   = cu;
            end
        end

        if (go && phase_next == PH_OPERAND)
        begin
            go = 1'b0;
            if (c == CH_NEWLINE || c == comment_reg)
            begin
                phase_next = PH_DONE;
            end
            else if (blank)
            begin
                phase_next = PH_OPERAND;
            end
            else if (c != quote_reg)
            begin
                emit        = 1'b1;
                kind        = KIND_OPERAND;
                ch          = cu;
                prev_f_next = (cu == CH_UPPER_F);
            end
            else
            begin
                emit = 1'b1;
                kind = KIND_OPERAND;
                ch   = c;
                if (!prev_f_reg)
                begin
                    phase_next = PH_STRING;
                end
                prev_f_next = 1'b0;
            end
        end
        else if (go && phase_next == PH_STRING)
        begin
            go = 1'b0;
            if (c == quote_reg)
            begin
                emit        = 1'b1;
                kind        = KIND_OPERAND;
                ch          = c;
                phase_next  = PH_OPERAND;
                prev_f_next = 1'b0;
            end
            else if (c == CH_NEWLINE || c == comment_reg)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                emit = 1'b1;
                kind = KIND_OPERAND;
                ch   = c;
            end
        end

        if (in_ch.line_last)
        begin
            phase_next       = PH_START;
            label_count_next = 6'd0;
            prev_f_next      = 1'b0;
        end
    end

    assign q_push            = accept && (emit || in_ch.line_last);
    assign q_data.has_char   = emit;
    assign q_data.kind       = kind;
    assign q_data.ch         = ch;
    assign q_data.line_end   = in_ch.line_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            label_count_reg  <= 6'd0;
            prev_f_reg       <= 1'b0;
            line_comment_reg <= RST_LINE_COMMENT;
            comment_reg      <= RST_COMMENT;
            label_sep_reg    <= RST_LABEL_SEP;
            quote_reg        <= RST_QUOTE;
            max_label_reg    <= RST_MAX_LABEL;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                label_count_reg <= label_count_next;
                prev_f_reg      <= prev_f_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LINE_COMMENT: line_comment_reg <= cfg_data;
                    CFG_COMMENT:      comment_reg      <= cfg_data;
                    CFG_LABEL_SEP:    label_sep_reg    <= cfg_data;
                    CFG_QUOTE:        quote_reg        <= cfg_data;
                    CFG_MAX_LABEL:    max_label_reg    <= cfg_data[5:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/alt_fifo.sv]
// Short record queue between the classifying front end and the result back end.
// Depends on alt_pkg.
`default_nettype none

module alt_fifo
    import alt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire alt_rec_t push_data,
    input  wire logic     pop,
    output alt_rec_t      pop_data,
    output logic          full,
    output logic          empty
);

    alt_rec_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_full_xor_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue both full and empty");

endmodule

`default_nettype wire

[hw/rtl/alt_back.sv]
// Back end: expands queue records into one or two result items behind an output register.
// Depends on alt_pkg, alt_if.
`default_nettype none

module alt_back
    import alt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alt_rec_t q_data,
    input  wire logic     q_empty,
    output logic          q_pop,
    alt_out_if.source     out_ch
);

    logic       out_valid_reg;
    alt_kind_t  kind_reg;
    logic [7:0] char_reg;
    logic       lor_reg;
    logic       pend_end_reg;
    logic       take;

    assign take  = !out_valid_reg || out_ch.ready;
    assign q_pop = take && !pend_end_reg && !q_empty;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.field_kind  = kind_reg;
    assign out_ch.out_char    = char_reg;
    assign out_ch.last_of_run = lor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_end_reg  <= 1'b0;
            kind_reg      <= KIND_LABEL;
            char_reg      <= CH_NUL;
            lor_reg       <= 1'b0;
        end
        else if (take)
        begin
            if (pend_end_reg)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= KIND_END;
                char_reg      <= CH_NUL;
                lor_reg       <= 1'b1;
                pend_end_reg  <= 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_reg <= 1'b1;
                if (q_data.has_char)
                begin
                    kind_reg     <= q_data.kind;
                    char_reg     <= q_data.ch;
                    lor_reg      <= !q_data.line_end;
                    pend_end_reg <= q_data.line_end;
                end
                else
                begin
                    kind_reg <= KIND_END;
                    char_reg <= CH_NUL;
                    lor_reg  <= 1'b1;
                end
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_pend_behind_char: assert property (@(posedge clk) disable iff (!rst_n)
        pend_end_reg |-> (out_valid_reg && !lor_reg && kind_reg != KIND_END))
        else $error("pending end marker without a char ahead of it");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_END) |-> (lor_reg && char_reg == CH_NUL))
        else $error("end marker not flagged last");

    a_no_pop_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_end_reg |-> !q_pop)
        else $error("queue popped while end marker pending");

endmodule

`default_nettype wire

[hw/rtl/assembler_line_tokenizer_top.sv]
// Top level of the assembler line tokenizer: front end, record queue, back end.
// Depends on alt_pkg, alt_if, alt_front, alt_fifo, alt_back.
`default_nettype none

// Takes one source byte per clock while the record queue is not full, and
// returns label, opcode and operand characters tagged with their field, plus
// an end marker on each line's final byte. Sustained rate is one item per
// cycle while the output is ready; a byte that yields both a field character
// and the end marker gives two output items, and the four-entry record queue
// between front and back end absorbs such bursts. The first result of an item
// passes through the record queue and then the back end's output register.
// Configuration writes must be made only while the block is idle.
module assembler_line_tokenizer_top
    import alt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    alt_in_if.sink                    in_ch,
    alt_out_if.source                 out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    alt_rec_t q_wdata;
    alt_rec_t q_rdata;

    alt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    alt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    alt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

[test/assembler_line_tokenizer_top_tb.sv]
// Self-checking testbench for assembler_line_tokenizer_top: drives source lines through
// the input channel, predicts the tagged field characters and checks every result item.
// Depends on alt_pkg, alt_if and the tokenizer RTL.
`timescale 1ns / 1ps

module assembler_line_tokenizer_top_tb
    import alt_pkg::*;
;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;

    typedef enum logic [2:0] {
        LN_START,
        LN_LABEL,
        LN_LABEL_TAIL,
        LN_OP_GAP,
        LN_OPCODE,
        LN_OPERAND,
        LN_STRING,
        LN_DONE
    } line_phase_t;

    typedef struct packed {
        alt_kind_t  kind;
        logic [7:0] ch;
        logic       last;
    } token_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    alt_in_if  char_bus ();
    alt_out_if token_bus ();

    assembler_line_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (char_bus),
        .out_ch    (token_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tokenizer state and register copies
    line_phase_t ln_phase = LN_START;
    logic [5:0]  lbl_count = '0;
    logic        after_f = 1'b0;
    logic [7:0]  cfg_line_comment = RST_LINE_COMMENT;
    logic [7:0]  cfg_comment = RST_COMMENT;
    logic [7:0]  cfg_sep = RST_LABEL_SEP;
    logic [7:0]  cfg_quote = RST_QUOTE;
    logic [5:0]  cfg_label_max = RST_MAX_LABEL;

    token_t      expected_tokens[$];
    logic [7:0]  line_buf[$];
    int          chars_sent = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          hold_request = 0;
    bit          src_gaps_on = 1'b1;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    function automatic logic is_white(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FFEED, CH_RETURN};
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_DELTA : c;
    endfunction

    function automatic token_t field_token(input alt_kind_t kind, input logic [7:0] ch);
        token_t t;
        t.kind = kind;
        t.ch   = ch;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void predict_tokens(input logic [7:0] c, input logic eol);
        token_t     batch[$];
        logic [7:0] u;
        bit         rescan;
        rescan = 1'b1;
        while (rescan)
        begin
            rescan = 1'b0;
            case (ln_phase)
                LN_START:
                    if (c == cfg_line_comment)
                        ln_phase = LN_DONE;
                    else
                    begin
                        ln_phase = LN_LABEL;
                        rescan = 1'b1;
                    end
                LN_LABEL:
                    if (is_white(c) || c == cfg_comment || c == cfg_sep ||
                        lbl_count >= cfg_label_max)
                    begin
                        ln_phase = LN_LABEL_TAIL;
                        rescan = 1'b1;
                    end
                    else
                    begin
                        batch.push_back(field_token(KIND_LABEL, upcase(c)));
                        lbl_count = lbl_count + 6'd1;
                    end
                LN_LABEL_TAIL:
                    if (c == cfg_sep)
                        ln_phase = LN_OP_GAP;
                    else if (is_white(c) || c == cfg_comment)
                    begin
                        ln_phase = LN_OP_GAP;
                        rescan = 1'b1;
                    end
                LN_OP_GAP:
                    if (c != CH_SPACE && c != CH_TAB)
                    begin
                        ln_phase = LN_OPCODE;
                        rescan = 1'b1;
                    end
                LN_OPCODE:
                    if (is_white(c) || c == cfg_comment)
                    begin
                        ln_phase = LN_OPERAND;
                        rescan = 1'b1;
                    end
                    else
                        batch.push_back(field_token(KIND_OPCODE, upcase(c)));
                LN_OPERAND:
                    if (c == CH_NEWLINE || c == cfg_comment)
                        ln_phase = LN_DONE;
                    else if (is_white(c))
                    begin
                    end
                    else if (c != cfg_quote)
                    begin
                        u = upcase(c);
                        batch.push_back(field_token(KIND_OPERAND, u));
                        after_f = (u == CH_UPPER_F);
                    end
                    else
                    begin
                        // quote right after F is the AF' register, not a string
                        batch.push_back(field_token(KIND_OPERAND, c));
                        if (!after_f)
                            ln_phase = LN_STRING;
                        after_f = 1'b0;
                    end
                LN_STRING:
                    if (c == cfg_quote)
                    begin
                        batch.push_back(field_token(KIND_OPERAND, c));
                        ln_phase = LN_OPERAND;
                        after_f = 1'b0;
                    end
                    else if (c == CH_NEWLINE || c == cfg_comment)
                        ln_phase = LN_DONE;
                    else
                        batch.push_back(field_token(KIND_OPERAND, c));
                default:
                begin
                end
            endcase
        end
        if (eol)
        begin
            batch.push_back(field_token(KIND_END, CH_NUL));
            ln_phase = LN_START;
            lbl_count = '0;
            after_f = 1'b0;
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_tokens.push_back(batch[i]);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eol);
        int gap;
        if ($urandom_range(0, 31) == 0)
            src_idle = !src_idle;
        gap = (src_gaps_on && src_idle) ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.in_char   <= c;
        char_bus.line_last <= eol;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        predict_tokens(c, eol);
        chars_sent++;
    endtask

    task automatic send_text(input string text, input logic eol);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], eol && (i == text.len() - 1));
    endtask

    task automatic wait_idle();
        char_bus.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] line_comment, input logic [7:0] comment,
                               input logic [7:0] sep, input logic [7:0] quote,
                               input logic [5:0] label_max);
        wait_idle();
        write_reg(CFG_LINE_COMMENT, line_comment);
        write_reg(CFG_COMMENT, comment);
        write_reg(CFG_LABEL_SEP, sep);
        write_reg(CFG_QUOTE, quote);
        write_reg(CFG_MAX_LABEL, {2'b00, label_max});
        cfg_we <= 1'b0;
        cfg_line_comment = line_comment;
        cfg_comment      = comment;
        cfg_sep          = sep;
        cfg_quote        = quote;
        cfg_label_max    = label_max;
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(65, 90));
            1: return 8'($urandom_range(97, 122));
            2: return 8'($urandom_range(48, 57));
            default: return $urandom_range(0, 1) ? CH_UPPER_F : CH_UPPER_F + CASE_DELTA;
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 7))
            0: return CH_VTAB;
            1: return CH_FFEED;
            2: return CH_RETURN;
            3, 4: return CH_TAB;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(32, 126));
    endfunction

    // mostly well-formed lines built from the current special characters, some noise
    function automatic void compose_line();
        int style;
        int n;
        line_buf.delete();
        style = $urandom_range(0, 19);
        if (style < 3)
        begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (style == 3)
            line_buf.push_back(cfg_line_comment);
        if (style == 4)
        begin
            line_buf.push_back(blank_char());
            return;
        end
        if ($urandom_range(0, 3) != 0)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 10);
            repeat (n) line_buf.push_back(word_char());
            if ($urandom_range(0, 1))
                line_buf.push_back(cfg_sep);
        end
        repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
        repeat ($urandom_range(1, 5)) line_buf.push_back(word_char());
        if ($urandom_range(0, 4) != 0)
        begin
            repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 5))
                    0: line_buf.push_back(",");
                    1: line_buf.push_back(blank_char());
                    2:
                    begin
                        line_buf.push_back($urandom_range(0, 1) ? 8'h41 : 8'h61);
                        line_buf.push_back(word_char() | 8'h00);
                        line_buf.push_back($urandom_range(0, 1) ? CH_UPPER_F
                                                                : CH_UPPER_F + CASE_DELTA);
                        line_buf.push_back(cfg_quote);
                    end
                    3:
                    begin
                        line_buf.push_back(cfg_quote);
                        repeat ($urandom_range(0, 6)) line_buf.push_back(text_char());
                        if ($urandom_range(0, 3) != 0)
                            line_buf.push_back(cfg_quote);
                    end
                    default: repeat ($urandom_range(1, 3)) line_buf.push_back(word_char());
                endcase
            end
        end
        case ($urandom_range(0, 5))
            0:
            begin
                line_buf.push_back(cfg_comment);
                repeat ($urandom_range(0, 5)) line_buf.push_back(text_char());
            end
            1:
            begin
                line_buf.push_back(CH_NEWLINE);
                repeat ($urandom_range(0, 3)) line_buf.push_back(word_char());
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic run_lines(input int count);
        int stop;
        stop = chars_sent + count;
        while (chars_sent < stop)
        begin
            compose_line();
            foreach (line_buf[i])
                send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic test_directed_lines();
        send_char(cfg_line_comment, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("l:ex af',';q", 1'b1);
        send_text("\tx 'a\n", 1'b0);
        send_char(CH_NUL, 1'b1);
        send_text("z", 1'b1);
    endtask

    task automatic test_random_lines();
        run_lines(300);
    endtask

    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        hold_request = HOLD_CYCLES;
        run_lines(90);
        src_gaps_on = 1'b1;
        wait_idle();
        run_lines(60);
    endtask

    task automatic test_midline_config();
        send_text("abcdef", 1'b0);
        load_config(cfg_line_comment, cfg_comment, cfg_sep, cfg_quote, 6'd3);
        send_text("gh: nop x", 1'b1);
        load_config(cfg_line_comment, cfg_comment, cfg_sep, cfg_quote, RST_MAX_LABEL);
    endtask

    task automatic test_config_sweep();
        load_config(8'h00, 8'h00, 8'h00, 8'h00, 6'd1);
        run_lines(95);
        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd63);
        run_lines(95);
        // quote is a blank, comment is the separator, no label kept
        load_config("a", ":", ":", CH_SPACE, 6'd0);
        run_lines(95);
        load_config(";", "#", "=", 8'h22, 6'd5);
        run_lines(95);
        load_config(8'($urandom_range(33, 126)), 8'($urandom_range(33, 126)),
                    8'($urandom_range(33, 126)), 8'($urandom_range(33, 126)),
                    6'($urandom_range(1, 63)));
        run_lines(95);
        load_config(RST_LINE_COMMENT, RST_COMMENT, RST_LABEL_SEP, RST_QUOTE, RST_MAX_LABEL);
        run_lines(95);
    endtask

    initial
    begin : token_sink
        int stall;
        token_bus.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                sink_idle = !sink_idle;
            stall = sink_idle ? $urandom_range(0, 13) : 0;
            if (hold_request > 0)
            begin
                stall = stall + hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                token_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            token_bus.ready <= 1'b1;
            @(posedge clk);
            while (!token_bus.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n === 1'b1 && token_bus.valid && token_bus.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected item: field_kind %0d out_char %02h last_of_run %0b",
                       token_bus.field_kind, token_bus.out_char, token_bus.last_of_run);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (token_bus.field_kind !== want.kind)
                begin
                    $error("field_kind: expected %0d, got %0d", want.kind,
                           token_bus.field_kind);
                    mismatches++;
                end
                if (token_bus.out_char !== want.ch)
                begin
                    $error("out_char: expected %02h, got %02h", want.ch, token_bus.out_char);
                    mismatches++;
                end
                if (token_bus.last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.last,
                           token_bus.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (char_bus.valid && char_bus.ready) ||
            (token_bus.valid && token_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n              <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.in_char   <= CH_NUL;
        char_bus.line_last <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_LINE_COMMENT;
        cfg_data           <= CH_NUL;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_lines();
        test_random_lines();
        test_backpressure();
        test_midline_config();
        test_config_sweep();
        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/alt_pkg.sv
hw/rtl/alt_if.sv
hw/rtl/alt_front.sv
hw/rtl/alt_fifo.sv
hw/rtl/alt_back.sv
hw/rtl/assembler_line_tokenizer_top.sv
test/assembler_line_tokenizer_top_tb.sv
